### rtl/core/mts_pkg.sv
// Shared types and codes for the min-tracking stack.
package mts_pkg;

  localparam int DEFAULT_STACK_DEPTH = 64;
  localparam int WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

### rtl/core/mts_if.sv
// Valid/ready channel interfaces for the min-tracking stack.
interface mts_in_if;
  import mts_pkg::*;
  logic  valid;
  logic  ready;
  logic [1:0] mode;
  word_t value;
  modport source (output valid, mode, value, input ready);
  modport sink (input valid, mode, value, output ready);
endinterface

interface mts_out_if;
  import mts_pkg::*;
  logic  valid;
  logic  ready;
  word_t top_value;
  word_t min_value;
  logic  is_empty;
  logic [1:0] status;
  modport source (output valid, top_value, min_value, is_empty, status, input ready);
  modport sink (input valid, top_value, min_value, is_empty, status, output ready);
endinterface

### rtl/core/min_tracking_stack_top.sv
// Min-tracking stack: signed 32-bit stack that reports its minimum on every item.
//
// Channels: in_ch carries mode (push, pop, query) and value; out_ch returns
// top_value, min_value, is_empty and status. Both use valid/ready; a transfer
// happens when valid and ready are high at a rising clock edge.
// Every input transfer yields exactly one result, valid in the cycle after the
// input transfer. One item is taken per cycle as long as the receiver takes
// results; the value and minimum stacks are rows of shift cells, so a push or
// pop moves every cell together and the tops sit in cell zero.
// A push on a full stack or a pop on an empty one leaves the stack untouched
// and reports status 1 or 2. Mode 3 acts as a query.
// Reset (rst, synchronous) empties both stacks and drops a pending result.
// While a result waits with out_ch.ready low, in_ch.ready is low and the
// stack holds; the result stays on out_ch until its transfer.
// top_value and min_value read zero when the stack is empty.
module min_tracking_stack_top
  import mts_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input logic      clk,
  input logic      rst,
  mts_in_if.sink   in_ch,
  mts_out_if.source out_ch
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  logic [CNT_W-1:0] value_count, value_count_next;
  logic [CNT_W-1:0] minimum_count, minimum_count_next;
  logic             out_valid;
  status_t          status, status_next;
  shift_ctl_t       vctl, mctl;
  word_t            vtop, mtop;
  logic             acc;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    vctl = '0;
    mctl = '0;
    status_next = ST_OK;
    value_count_next = value_count;
    minimum_count_next = minimum_count;
    if (acc) begin
      unique case (in_ch.mode)
        MODE_PUSH: begin
          if (value_count == FULL_CNT) begin
            status_next = ST_FULL;
          end else begin
            vctl.push = 1'b1;
            value_count_next = value_count + ONE_CNT;
            if (minimum_count != FULL_CNT &&
                (minimum_count == '0 || in_ch.value <= mtop)) begin
              mctl.push = 1'b1;
              minimum_count_next = minimum_count + ONE_CNT;
            end
          end
        end
        MODE_POP: begin
          if (value_count == '0) begin
            status_next = ST_EMPTY;
          end else begin
            vctl.pop = 1'b1;
            value_count_next = value_count - ONE_CNT;
            if (minimum_count != '0 && mtop == vtop) begin
              mctl.pop = 1'b1;
              minimum_count_next = minimum_count - ONE_CNT;
            end
          end
        end
        default: begin
          status_next = ST_OK;
        end
      endcase
    end
  end

  mts_chain #(.STACK_DEPTH(STACK_DEPTH)) u_value_chain (
    .clk (clk),
    .ctl (vctl),
    .din (in_ch.value),
    .top (vtop)
  );

  mts_chain #(.STACK_DEPTH(STACK_DEPTH)) u_min_chain (
    .clk (clk),
    .ctl (mctl),
    .din (in_ch.value),
    .top (mtop)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      value_count <= '0;
      minimum_count <= '0;
      out_valid <= 1'b0;
      status <= ST_OK;
    end else begin
      value_count <= value_count_next;
      minimum_count <= minimum_count_next;
      if (acc) begin
        out_valid <= 1'b1;
        status <= status_next;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.top_value = (value_count == '0) ? '0 : vtop;
  assign out_ch.min_value = (minimum_count == '0) ? '0 : mtop;
  assign out_ch.is_empty = (value_count == '0);
  assign out_ch.status = status;

  a_min_le_value: assert property (@(posedge clk) disable iff (rst)
    minimum_count <= value_count)
    else $error("minimum stack deeper than value stack");

  a_empty_min: assert property (@(posedge clk) disable iff (rst)
    value_count == '0 |-> minimum_count == '0)
    else $error("minimum entries left on empty stack");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    acc && in_ch.mode == MODE_PUSH && value_count != FULL_CNT
    |=> value_count == $past(value_count) + ONE_CNT && status == ST_OK)
    else $error("push did not grow the stack");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    acc && in_ch.mode == MODE_POP && value_count == '0
    |=> value_count == '0 && status == ST_EMPTY)
    else $error("pop on empty not flagged");

  a_push_full: assert property (@(posedge clk) disable iff (rst)
    acc && in_ch.mode == MODE_PUSH && value_count == FULL_CNT
    |=> value_count == FULL_CNT && status == ST_FULL)
    else $error("push on full not flagged");

endmodule

### rtl/core/mts_cell.sv
// One stack cell: holds a word and shifts it toward or away from the top.
module mts_cell
  import mts_pkg::*;
(
  input  logic       clk,
  input  shift_ctl_t ctl,
  input  word_t      from_above,
  input  word_t      from_below,
  output word_t      data
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      data <= from_above;
    end else if (ctl.pop) begin
      data <= from_below;
    end
  end

endmodule

### rtl/core/mts_chain.sv
// Row of stack cells; cell zero holds the top entry.
module mts_chain
  import mts_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic       clk,
  input  shift_ctl_t ctl,
  input  word_t      din,
  output word_t      top
);

  word_t q [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    word_t above;
    word_t below;
    if (i == 0) begin : g_first
      assign above = din;
    end else begin : g_inner
      assign above = q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_rest
      assign below = q[i+1];
    end
    mts_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .from_above (above),
      .from_below (below),
      .data       (q[i])
    );
  end

  assign top = q[0];

endmodule
